@@ sv/wpyz_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpyz_pkg
// Shared widths, reset values and register indexes of the weighted y-z fit.
// ----------------------------------------------------------------------------
package wpyz_pkg;

   // field widths
   localparam int POS_W     = 24;
   localparam int SIG_W     = 16;
   localparam int CHI_W     = 32;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   // quotient bits and dividend widths of the two divider kinds
   localparam int QY_W = 24;
   localparam int DY_W = 108;
   localparam int QC_W = 32;
   localparam int DC_W = 85;

   // register reset values
   localparam logic signed [CSR_W-1:0] TRIG_RESET   = 16'sd11585;
   localparam logic        [CSR_W-1:0] HEIGHT_RESET = 16'd0;

   // saturation limits of the fitted coordinates
   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIN_U  = 3'd0,
      REG_COS_U  = 3'd1,
      REG_SIN_V  = 3'd2,
      REG_COS_V  = 3'd3,
      REG_HEIGHT = 3'd4
   } csr_reg_type;

endpackage
`default_nettype wire

@@ sv/wpyz_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpyz_div
// Pipelined restoring divider: one quotient bit per stage, with an
// overflow flag raised when the quotient does not fit in QB bits.
// ----------------------------------------------------------------------------
module wpyz_div #(
   parameter int W  = 8,
   parameter int QB = 4
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   output logic [QB-1:0] quot,
   output logic          ovf
);

   logic [W-1:0]  rem_ff  [QB+1];
   logic [W-1:0]  den_ff  [QB+1];
   logic [QB-1:0] quot_ff [QB+1];
   logic          ovf_ff  [QB+1];

   // overflow check, then one compare and subtract per stage
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         quot_ff[0] <= '0;
         ovf_ff[0]  <= (num >> QB) >= den;
         for (int k = 1; k <= QB; k++) begin
            if ((rem_ff[k-1] >> (QB - k)) >= den_ff[k-1]) begin
               rem_ff[k]  <= rem_ff[k-1] - (den_ff[k-1] << (QB - k));
               quot_ff[k] <= quot_ff[k-1] | (QB'(1) << (QB - k));
            end else begin
               rem_ff[k]  <= rem_ff[k-1];
               quot_ff[k] <= quot_ff[k-1];
            end
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = quot_ff[QB];
   assign ovf  = ovf_ff[QB];

endmodule
`default_nettype wire

@@ sv/wire_plane_weighted_yz_fit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wire_plane_weighted_yz_fit
// Weighted closed-form y-z fit from U, V, W wire coordinates, with chi-squared.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one hit word: three coordinates and three sigmas.
//   rsp_* returns one word per hit: y, z, chi-squared and an error flag.
//   A word moves when valid is high and stall is low at a rising edge.
//   csr_* writes the wire-angle sines and cosines and the detector height;
//   write them only while no hit is in flight.
// Pipeline, from acceptance to rsp_valid: 9 arithmetic stages, a 25-stage
//   y/z divider, stage 10, the back-projection stages, a 33-stage chi divider
//   and the output register.
// Throughput: one hit per cycle while nothing stalls; every stage advances together.
// Reset: synchronous; empties the pipeline and restores register defaults.
// Stall: while rsp_stall holds a waiting result, the whole pipeline freezes
//   and req_stall is raised; nothing is lost or repeated.
// A zero sigma or zero denominator gives fit_error with zero outputs.
// ----------------------------------------------------------------------------
module wire_plane_weighted_yz_fit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [wpyz_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wpyz_pkg::CSR_W-1:0]          csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wpyz_pkg::POS_W-1:0]   req_u_pos,
   input  logic signed [wpyz_pkg::POS_W-1:0]   req_v_pos,
   input  logic signed [wpyz_pkg::POS_W-1:0]   req_w_pos,
   input  logic [wpyz_pkg::SIG_W-1:0]          req_sigma_u_in,
   input  logic [wpyz_pkg::SIG_W-1:0]          req_sigma_v_in,
   input  logic [wpyz_pkg::SIG_W-1:0]          req_sigma_w_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [wpyz_pkg::POS_W-1:0]   rsp_y_pos,
   output logic signed [wpyz_pkg::POS_W-1:0]   rsp_z_pos,
   output logic [wpyz_pkg::CHI_W-1:0]          rsp_chi_squared,
   output logic                                rsp_fit_error
);
   import wpyz_pkg::*;

   localparam int LAT = 9 + (QY_W + 1) + 1 + 4 + (QC_W + 1);
   localparam int S9  = 8;

   typedef struct packed {
      logic               err;
      logic               y_neg;
      logic               z_neg;
      logic signed [23:0] w;
      logic signed [38:0] pu;
      logic signed [38:0] pv;
      logic [15:0]        su;
      logic [15:0]        sv;
      logic [15:0]        sw;
   } yside_type;

   typedef struct packed {
      logic               err;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } cside_type;

   // configuration registers
   logic signed [15:0] sin_u_ff, cos_u_ff, sin_v_ff, cos_v_ff;
   logic [15:0]        height_ff;
   logic signed [16:0] h_s;

   // pipeline control
   logic           adv;
   logic [LAT-1:0] vld_ff;
   logic           rsp_valid_ff;

   // stage 1
   logic signed [38:0] s1_pu_ff, s1_pv_ff;
   logic signed [32:0] s1_oq_ff;
   logic signed [31:0] s1_pa_ff, s1_pb_ff, s1_a2_ff, s1_c2_ff;
   logic signed [39:0] s1_wb_ff, s1_we_ff;
   logic signed [23:0] s1_w_ff;
   logic [15:0]        s1_su_ff, s1_sv_ff, s1_sw_ff;
   logic               s1_err_ff;
   // stage 2
   logic signed [32:0] s2_p_ff;
   logic signed [48:0] s2_lina_ff, s2_linb_ff;
   logic signed [41:0] s2_a1_ff, s2_c1_ff;
   logic signed [39:0] s2_d1_ff, s2_d2_ff, s2_e1_ff;
   logic signed [38:0] s2_pu_ff, s2_pv_ff;
   logic signed [23:0] s2_w_ff;
   logic [15:0]        s2_su_ff, s2_sv_ff, s2_sw_ff;
   logic               s2_err_ff;
   // stage 3
   logic signed [49:0] s3_lin_ff;
   logic signed [65:0] s3_pp_ff;
   logic signed [57:0] s3_y1_ff, s3_y2_ff;
   logic signed [55:0] s3_y3a_ff, s3_y3b_ff, s3_z3a_ff, s3_z3b_ff;
   logic signed [32:0] s3_p_ff;
   logic signed [38:0] s3_pu_ff, s3_pv_ff;
   logic signed [23:0] s3_w_ff;
   logic [15:0]        s3_su_ff, s3_sv_ff, s3_sw_ff;
   logic               s3_err_ff;
   // stage 4
   logic signed [82:0] s4_ppsw_ff;
   logic signed [74:0] s4_ny1_ff, s4_ny2_ff;
   logic signed [56:0] s4_x3_ff, s4_z3_ff;
   logic signed [73:0] s4_lw_ff;
   logic signed [49:0] s4_lin_ff;
   logic signed [32:0] s4_p_ff;
   logic signed [38:0] s4_pu_ff, s4_pv_ff;
   logic signed [23:0] s4_w_ff;
   logic [15:0]        s4_su_ff, s4_sv_ff, s4_sw_ff;
   logic               s4_err_ff;
   // stage 5
   logic signed [82:0]  s5_d_ff;
   logic signed [105:0] s5_nya_ff, s5_nza_ff;
   logic signed [62:0]  s5_xlo_ff, s5_zlo_ff;
   logic signed [60:0]  s5_xhi_ff, s5_zhi_ff;
   logic signed [38:0]  s5_pu_ff, s5_pv_ff;
   logic signed [23:0]  s5_w_ff;
   logic [15:0]         s5_su_ff, s5_sv_ff, s5_sw_ff;
   logic                s5_err_ff;
   // stage 6
   logic signed [90:0]  s6_x3p_ff, s6_z3p_ff;
   logic signed [82:0]  s6_d_ff;
   logic signed [105:0] s6_nya_ff, s6_nza_ff;
   logic signed [38:0]  s6_pu_ff, s6_pv_ff;
   logic signed [23:0]  s6_w_ff;
   logic [15:0]         s6_su_ff, s6_sv_ff, s6_sw_ff;
   logic                s6_err_ff;
   // stage 7
   logic signed [107:0] s7_t3_ff, s7_t3z_ff;
   logic signed [82:0]  s7_d_ff;
   logic signed [105:0] s7_nya_ff, s7_nza_ff;
   logic signed [38:0]  s7_pu_ff, s7_pv_ff;
   logic signed [23:0]  s7_w_ff;
   logic [15:0]         s7_su_ff, s7_sv_ff, s7_sw_ff;
   logic                s7_err_ff;
   // stage 8
   logic signed [107:0] s8_ny_ff, s8_nz_ff;
   logic signed [82:0]  s8_d_ff;
   logic signed [38:0]  s8_pu_ff, s8_pv_ff;
   logic signed [23:0]  s8_w_ff;
   logic [15:0]         s8_su_ff, s8_sv_ff, s8_sw_ff;
   logic                s8_err_ff;
   // stage 9
   logic [DY_W-1:0]     y_mag_w, z_mag_w;
   logic [DY_W-1:0]     s9_ny_ff, s9_nz_ff, s9_dv_ff;
   yside_type           s9_side_ff;
   // y/z divider
   yside_type           ydly_ff [QY_W+1];
   logic [QY_W-1:0]     yq, zq;
   logic                y_ovf, z_ovf;
   yside_type           yside;
   logic signed [23:0]  y_in, z_in;
   // stage 10
   logic signed [23:0]  s10_y_ff, s10_z_ff;
   yside_type           s10_side_ff;
   // back-projection stages
   logic signed [40:0]  c1_zb_ff, c1_ze_ff, c1_dw_ff;
   logic signed [42:0]  c1_ya_ff, c1_yc_ff;
   logic signed [38:0]  c1_pu_ff, c1_pv_ff;
   logic [31:0]         c1_s2_ff [3];
   cside_type           c1_cs_ff;
   logic signed [43:0]  du_w, dv_w;
   logic [41:0]         c2_mag_ff [3];
   logic [31:0]         c2_s2_ff [3];
   cside_type           c2_cs_ff;
   logic [41:0]         c3_hh_ff [3];
   logic [41:0]         c3_hl_ff [3];
   logic [41:0]         c3_ll_ff [3];
   logic [31:0]         c3_s2_ff [3];
   cside_type           c3_cs_ff;
   logic [DC_W-1:0]     c4_num_ff [3];
   logic [DC_W-1:0]     c4_den_ff [3];
   cside_type           c4_cs_ff;
   // chi divider and output
   cside_type           cdly_ff [QC_W+1];
   logic [QC_W-1:0]     c_q [3];
   logic [2:0]          c_ovf;
   logic [CHI_W+1:0]    chi_sum;
   logic [CHI_W-1:0]    chi_in;
   logic signed [23:0]  rsp_y_ff, rsp_z_ff;
   logic [CHI_W-1:0]    rsp_chi_ff;
   logic                rsp_err_ff;

   assign h_s = $signed({1'b0, height_ff});

   // whole pipeline moves unless a waiting result is stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // configuration and valid tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         sin_u_ff     <= TRIG_RESET;
         cos_u_ff     <= TRIG_RESET;
         sin_v_ff     <= TRIG_RESET;
         cos_v_ff     <= TRIG_RESET;
         height_ff    <= HEIGHT_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_SIN_U:  sin_u_ff  <= $signed(csr_data);
               REG_COS_U:  cos_u_ff  <= $signed(csr_data);
               REG_SIN_V:  sin_v_ff  <= $signed(csr_data);
               REG_COS_V:  cos_v_ff  <= $signed(csr_data);
               REG_HEIGHT: height_ff <= csr_data;
               default:    ;
            endcase
         end
         if (adv) begin
            vld_ff       <= {vld_ff[LAT-2:0], req_valid};
            rsp_valid_ff <= vld_ff[LAT-1];
         end
      end
   end

   // stages 1 to 4: scaled inputs, trig products, partial numerators
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pu_ff  <= $signed({req_u_pos, 15'd0});
         s1_pv_ff  <= $signed({req_v_pos, 15'd0});
         s1_oq_ff  <= h_s * sin_u_ff;
         s1_pa_ff  <= sin_u_ff * cos_v_ff;
         s1_pb_ff  <= sin_v_ff * cos_u_ff;
         s1_a2_ff  <= sin_u_ff * sin_u_ff;
         s1_c2_ff  <= sin_v_ff * sin_v_ff;
         s1_wb_ff  <= req_w_pos * cos_u_ff;
         s1_we_ff  <= req_w_pos * cos_v_ff;
         s1_w_ff   <= req_w_pos;
         s1_su_ff  <= req_sigma_u_in;
         s1_sv_ff  <= req_sigma_v_in;
         s1_sw_ff  <= req_sigma_w_in;
         s1_err_ff <= (req_sigma_u_in == '0) || (req_sigma_v_in == '0) ||
                      (req_sigma_w_in == '0);

         s2_p_ff    <= s1_pa_ff + s1_pb_ff;
         s2_lina_ff <= $signed({1'b0, s1_sv_ff}) * s1_a2_ff;
         s2_linb_ff <= $signed({1'b0, s1_su_ff}) * s1_c2_ff;
         s2_a1_ff   <= s1_pu_ff - s1_oq_ff - (s1_wb_ff <<< 1);
         s2_c1_ff   <= s1_oq_ff - s1_pv_ff + (s1_we_ff <<< 1);
         s2_d1_ff   <= s1_oq_ff - s1_pv_ff;
         s2_d2_ff   <= s1_pu_ff - s1_oq_ff;
         s2_e1_ff   <= s1_pv_ff - s1_oq_ff;
         s2_pu_ff   <= s1_pu_ff;
         s2_pv_ff   <= s1_pv_ff;
         s2_w_ff    <= s1_w_ff;
         s2_su_ff   <= s1_su_ff;
         s2_sv_ff   <= s1_sv_ff;
         s2_sw_ff   <= s1_sw_ff;
         s2_err_ff  <= s1_err_ff;

         s3_lin_ff <= s2_lina_ff + s2_linb_ff;
         s3_pp_ff  <= s2_p_ff * s2_p_ff;
         s3_y1_ff  <= sin_u_ff * s2_a1_ff;
         s3_y2_ff  <= sin_v_ff * s2_c1_ff;
         s3_y3a_ff <= cos_u_ff * s2_d1_ff;
         s3_y3b_ff <= cos_v_ff * s2_d2_ff;
         s3_z3a_ff <= sin_u_ff * s2_e1_ff;
         s3_z3b_ff <= sin_v_ff * s2_d2_ff;
         s3_p_ff   <= s2_p_ff;
         s3_pu_ff  <= s2_pu_ff;
         s3_pv_ff  <= s2_pv_ff;
         s3_w_ff   <= s2_w_ff;
         s3_su_ff  <= s2_su_ff;
         s3_sv_ff  <= s2_sv_ff;
         s3_sw_ff  <= s2_sw_ff;
         s3_err_ff <= s2_err_ff;

         s4_ppsw_ff <= s3_pp_ff * $signed({1'b0, s3_sw_ff});
         s4_ny1_ff  <= s3_y1_ff * $signed({1'b0, s3_sv_ff});
         s4_ny2_ff  <= s3_y2_ff * $signed({1'b0, s3_su_ff});
         s4_x3_ff   <= s3_y3a_ff + s3_y3b_ff;
         s4_z3_ff   <= s3_z3a_ff + s3_z3b_ff;
         s4_lw_ff   <= s3_lin_ff * s3_w_ff;
         s4_lin_ff  <= s3_lin_ff;
         s4_p_ff    <= s3_p_ff;
         s4_pu_ff   <= s3_pu_ff;
         s4_pv_ff   <= s3_pv_ff;
         s4_w_ff    <= s3_w_ff;
         s4_su_ff   <= s3_su_ff;
         s4_sv_ff   <= s3_sv_ff;
         s4_sw_ff   <= s3_sw_ff;
         s4_err_ff  <= s3_err_ff;
      end
   end

   // stages 5 to 8: denominator and full numerators
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_d_ff   <= (s4_lin_ff <<< 28) + s4_ppsw_ff;
         s5_nya_ff <= (s4_ny1_ff + s4_ny2_ff) <<< 28;
         s5_nza_ff <= s4_lw_ff <<< 29;
         s5_xlo_ff <= $signed({1'b0, s4_x3_ff[28:0]}) * s4_p_ff;
         s5_xhi_ff <= $signed(s4_x3_ff[56:29]) * s4_p_ff;
         s5_zlo_ff <= $signed({1'b0, s4_z3_ff[28:0]}) * s4_p_ff;
         s5_zhi_ff <= $signed(s4_z3_ff[56:29]) * s4_p_ff;
         s5_pu_ff  <= s4_pu_ff;
         s5_pv_ff  <= s4_pv_ff;
         s5_w_ff   <= s4_w_ff;
         s5_su_ff  <= s4_su_ff;
         s5_sv_ff  <= s4_sv_ff;
         s5_sw_ff  <= s4_sw_ff;
         s5_err_ff <= s4_err_ff;

         s6_x3p_ff <= (s5_xhi_ff <<< 29) + s5_xlo_ff;
         s6_z3p_ff <= (s5_zhi_ff <<< 29) + s5_zlo_ff;
         s6_d_ff   <= s5_d_ff;
         s6_nya_ff <= s5_nya_ff;
         s6_nza_ff <= s5_nza_ff;
         s6_pu_ff  <= s5_pu_ff;
         s6_pv_ff  <= s5_pv_ff;
         s6_w_ff   <= s5_w_ff;
         s6_su_ff  <= s5_su_ff;
         s6_sv_ff  <= s5_sv_ff;
         s6_sw_ff  <= s5_sw_ff;
         s6_err_ff <= s5_err_ff || (s5_d_ff == '0);

         s7_t3_ff  <= s6_x3p_ff * $signed({1'b0, s6_sw_ff});
         s7_t3z_ff <= s6_z3p_ff * $signed({1'b0, s6_sw_ff});
         s7_d_ff   <= s6_d_ff;
         s7_nya_ff <= s6_nya_ff;
         s7_nza_ff <= s6_nza_ff;
         s7_pu_ff  <= s6_pu_ff;
         s7_pv_ff  <= s6_pv_ff;
         s7_w_ff   <= s6_w_ff;
         s7_su_ff  <= s6_su_ff;
         s7_sv_ff  <= s6_sv_ff;
         s7_sw_ff  <= s6_sw_ff;
         s7_err_ff <= s6_err_ff;

         s8_ny_ff  <= s7_nya_ff + s7_t3_ff;
         s8_nz_ff  <= s7_nza_ff + s7_t3z_ff;
         s8_d_ff   <= s7_d_ff;
         s8_pu_ff  <= s7_pu_ff;
         s8_pv_ff  <= s7_pv_ff;
         s8_w_ff   <= s7_w_ff;
         s8_su_ff  <= s7_su_ff;
         s8_sv_ff  <= s7_sv_ff;
         s8_sw_ff  <= s7_sw_ff;
         s8_err_ff <= s7_err_ff;
      end
   end

   // stage 9: magnitudes, rounding offset and doubled divisor
   // y is minus the stored numerator, so its sign is the opposite one
   assign y_mag_w = s8_ny_ff[107] ? DY_W'(-s8_ny_ff) : DY_W'(s8_ny_ff);
   assign z_mag_w = s8_nz_ff[107] ? DY_W'(-s8_nz_ff) : DY_W'(s8_nz_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_ny_ff         <= y_mag_w + DY_W'(s8_d_ff[79:0]);
         s9_nz_ff         <= z_mag_w + DY_W'(s8_d_ff[79:0]);
         s9_dv_ff         <= DY_W'({s8_d_ff[79:0], 1'b0});
         s9_side_ff.err   <= s8_err_ff;
         s9_side_ff.y_neg <= !s8_ny_ff[107] && (s8_ny_ff != '0);
         s9_side_ff.z_neg <= s8_nz_ff[107];
         s9_side_ff.w     <= s8_w_ff;
         s9_side_ff.pu    <= s8_pu_ff;
         s9_side_ff.pv    <= s8_pv_ff;
         s9_side_ff.su    <= s8_su_ff;
         s9_side_ff.sv    <= s8_sv_ff;
         s9_side_ff.sw    <= s8_sw_ff;
      end
   end

   // rounded y and z quotients
   wpyz_div #(.W(DY_W), .QB(QY_W)) u_div_y (
      .clock  (clock),
      .enable (adv),
      .num    (s9_ny_ff),
      .den    (s9_dv_ff),
      .quot   (yq),
      .ovf    (y_ovf)
   );

   wpyz_div #(.W(DY_W), .QB(QY_W)) u_div_z (
      .clock  (clock),
      .enable (adv),
      .num    (s9_nz_ff),
      .den    (s9_dv_ff),
      .quot   (zq),
      .ovf    (z_ovf)
   );

   // side data delay matching the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         ydly_ff[0] <= s9_side_ff;
         for (int k = 1; k <= QY_W; k++) begin
            ydly_ff[k] <= ydly_ff[k-1];
         end
      end
   end

   // sign and saturation of the fitted point
   always_comb begin
      yside = ydly_ff[QY_W];
      if (yside.y_neg) begin
         y_in = (y_ovf || yq > 24'h800000) ? POS_MIN : $signed(-yq);
      end else begin
         y_in = (y_ovf || yq > 24'h7FFFFF) ? POS_MAX : $signed(yq);
      end
      if (yside.z_neg) begin
         z_in = (z_ovf || zq > 24'h800000) ? POS_MIN : $signed(-zq);
      end else begin
         z_in = (z_ovf || zq > 24'h7FFFFF) ? POS_MAX : $signed(zq);
      end
      if (yside.err) begin
         y_in = '0;
         z_in = '0;
      end
   end

   // back-projection residual sums
   assign du_w = c1_pu_ff - c1_zb_ff + c1_ya_ff;
   assign dv_w = c1_pv_ff - c1_ze_ff - c1_yc_ff;

   // stage 10 and back-projection stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s10_y_ff    <= y_in;
         s10_z_ff    <= z_in;
         s10_side_ff <= yside;

         c1_zb_ff     <= (s10_z_ff * cos_u_ff) <<< 1;
         c1_ze_ff     <= (s10_z_ff * cos_v_ff) <<< 1;
         c1_ya_ff     <= ((s10_y_ff <<< 1) - h_s) * sin_u_ff;
         c1_yc_ff     <= ((s10_y_ff <<< 1) + h_s) * sin_v_ff;
         c1_dw_ff     <= (s10_side_ff.w - s10_z_ff) <<< 15;
         c1_pu_ff     <= s10_side_ff.pu;
         c1_pv_ff     <= s10_side_ff.pv;
         c1_s2_ff[0]  <= s10_side_ff.su * s10_side_ff.su;
         c1_s2_ff[1]  <= s10_side_ff.sv * s10_side_ff.sv;
         c1_s2_ff[2]  <= s10_side_ff.sw * s10_side_ff.sw;
         c1_cs_ff.err <= s10_side_ff.err;
         c1_cs_ff.y   <= s10_y_ff;
         c1_cs_ff.z   <= s10_z_ff;

         c2_mag_ff[0] <= du_w[43] ? 42'(-du_w) : 42'(du_w);
         c2_mag_ff[1] <= dv_w[43] ? 42'(-dv_w) : 42'(dv_w);
         c2_mag_ff[2] <= c1_dw_ff[40] ? 42'(-c1_dw_ff) : 42'(c1_dw_ff);
         c2_cs_ff     <= c1_cs_ff;
         c3_cs_ff     <= c2_cs_ff;
         c4_cs_ff     <= c3_cs_ff;

         // square split in halves, then numerator with half-divisor rounding
         for (int k = 0; k < 3; k++) begin
            c2_s2_ff[k]  <= c1_s2_ff[k];
            c3_hh_ff[k]  <= c2_mag_ff[k][41:21] * c2_mag_ff[k][41:21];
            c3_hl_ff[k]  <= c2_mag_ff[k][41:21] * c2_mag_ff[k][20:0];
            c3_ll_ff[k]  <= c2_mag_ff[k][20:0] * c2_mag_ff[k][20:0];
            c3_s2_ff[k]  <= c2_s2_ff[k];
            c4_num_ff[k] <= (DC_W'(c3_hh_ff[k]) << 42) + (DC_W'(c3_hl_ff[k]) << 22) +
                            DC_W'(c3_ll_ff[k]) + (DC_W'(c3_s2_ff[k]) << 5);
            c4_den_ff[k] <= DC_W'(c3_s2_ff[k]) << 6;
         end
      end
   end

   // one chi-squared term per plane
   for (genvar k = 0; k < 3; k++) begin : g_chi
      wpyz_div #(.W(DC_W), .QB(QC_W)) u_div_chi (
         .clock  (clock),
         .enable (adv),
         .num    (c4_num_ff[k]),
         .den    (c4_den_ff[k]),
         .quot   (c_q[k]),
         .ovf    (c_ovf[k])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cdly_ff[0] <= c4_cs_ff;
         for (int k = 1; k <= QC_W; k++) begin
            cdly_ff[k] <= cdly_ff[k-1];
         end
      end
   end

   // saturating sum of the three terms
   always_comb begin
      chi_sum = '0;
      for (int k = 0; k < 3; k++) begin
         chi_sum = chi_sum + (c_ovf[k] ? (CHI_W+2)'({CHI_W{1'b1}}) : (CHI_W+2)'(c_q[k]));
      end
      chi_in = (chi_sum[CHI_W+1:CHI_W] != 2'b00) ? {CHI_W{1'b1}} : chi_sum[CHI_W-1:0];
      if (cdly_ff[QC_W].err) begin
         chi_in = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_y_ff   <= cdly_ff[QC_W].y;
         rsp_z_ff   <= cdly_ff[QC_W].z;
         rsp_chi_ff <= chi_in;
         rsp_err_ff <= cdly_ff[QC_W].err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_y_pos       = rsp_y_ff;
   assign rsp_z_pos       = rsp_z_ff;
   assign rsp_chi_squared = rsp_chi_ff;
   assign rsp_fit_error   = rsp_err_ff;

   // an error word carries all-zero results
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_y_ff == '0 && rsp_z_ff == '0 && rsp_chi_ff == '0)
      else $error("error word with nonzero results");

   // error flag at the divider input matches sigmas and denominator
   a_err_track : assert property (@(posedge clock) disable iff (reset)
      vld_ff[S9] |-> s9_side_ff.err == (s9_side_ff.su == '0 || s9_side_ff.sv == '0 ||
                                        s9_side_ff.sw == '0 || s9_dv_ff == '0))
      else $error("error flag lost in the front stages");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> vld_ff == '0 && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
